// ===== hw/rtl/tlssni_pkg.sv =====
// Types and constants for the TLS ClientHello server-name extractor.
// No dependencies; used by tlssni_step and the top level.
package tlssni_pkg;

  localparam logic [7:0]  CONTENT_HANDSHAKE = 8'h16;
  localparam logic [7:0]  HS_CLIENT_HELLO   = 8'h01;
  localparam logic [15:0] SESSION_ID_POS    = 16'd43;
  localparam logic [15:0] SNI_KIND          = 16'h0000;
  localparam logic [15:0] SNI_HEADER_BYTES  = 16'd5;
  localparam logic [15:0] EXT_HEADER_BYTES  = 16'd4;
  localparam logic [16:0] RECORD_HDR_BYTES  = 17'd5;
  localparam logic [15:0] POS_MAX           = 16'hFFFF;

  localparam logic [1:0] ST_NAME       = 2'd0;
  localparam logic [1:0] ST_NO_NAME    = 2'd1;
  localparam logic [1:0] ST_NOT_HELLO  = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE, PH_HEADER, PH_SID_LEN, PH_SID_SKIP, PH_CS_HI, PH_CS_LO,
    PH_CS_SKIP, PH_CM_LEN, PH_CM_SKIP, PH_EXT_TOTAL, PH_EXT_HDR,
    PH_EXT_SKIP, PH_SNI_HDR, PH_NAME, PH_WAIT_END, PH_DONE
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] byte_position;
    logic [15:0] record_end;
    logic [15:0] field_remaining;
    logic [15:0] extension_kind;
    logic [7:0]  length_high_byte;
    logic        name_reported;
  } parse_state_t;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       last_of_name;
    logic [1:0] status;
  } result_t;

  localparam parse_state_t STATE_RESET = '{
    phase: PH_IDLE, byte_position: 16'd0, record_end: 16'd0,
    field_remaining: 16'd0, extension_kind: 16'd0,
    length_high_byte: 8'd0, name_reported: 1'b0
  };

endpackage

// ===== hw/rtl/tlssni_step.sv =====
// Per-byte parse step: next parser state and optional result for one byte.
// Depends on tlssni_pkg.
module tlssni_step import tlssni_pkg::*; (
  input  parse_state_t st,
  input  logic [7:0]   data_byte,
  input  logic         first_byte,
  output parse_state_t st_next,
  output logic         res_valid,
  output result_t      res
);

  always_comb begin
    parse_state_t s;
    logic        at_end;
    logic [15:0] fr_dec;
    logic [15:0] len16;
    logic [16:0] len17;
    logic [15:0] pos;
    logic        last;

    s = st;
    if (first_byte) begin
      s = STATE_RESET;
      s.phase = PH_HEADER;
    end
    res_valid = 1'b0;
    res = '{name_byte: 8'd0, last_of_name: 1'b1, status: ST_NOT_HELLO};
    pos = s.byte_position;
    at_end = (s.record_end != 16'd0) && ({1'b0, pos} + 17'd1 == {1'b0, s.record_end});
    fr_dec = s.field_remaining - 16'd1;
    len16 = {s.length_high_byte, data_byte};
    len17 = {1'b0, len16} + RECORD_HDR_BYTES;
    last = 1'b0;

    if (s.phase != PH_IDLE && s.phase != PH_DONE) begin
      case (s.phase)
        PH_HEADER: begin
          if (pos == 16'd0 && data_byte != CONTENT_HANDSHAKE) begin
            s.phase = PH_DONE;
            res_valid = 1'b1;
          end else begin
            if (pos == 16'd3) s.length_high_byte = data_byte;
            if (pos == 16'd4) begin
              if (len16 == 16'd0) begin
                s.phase = PH_DONE;
                res_valid = 1'b1;
              end else begin
                s.record_end = len17[16] ? POS_MAX : len17[15:0];
              end
            end
            if (!res_valid) begin
              if (pos == 16'd5 && data_byte != HS_CLIENT_HELLO) begin
                s.phase = PH_DONE;
                res_valid = 1'b1;
              end else if (pos == SESSION_ID_POS - 16'd1) begin
                s.phase = PH_SID_LEN;
              end
            end
          end
        end
        PH_SID_LEN: begin
          s.field_remaining = {8'd0, data_byte};
          s.phase = (data_byte != 8'd0) ? PH_SID_SKIP : PH_CS_HI;
        end
        PH_SID_SKIP: begin
          s.field_remaining = fr_dec;
          if (fr_dec == 16'd0) s.phase = PH_CS_HI;
        end
        PH_CS_HI: begin
          s.length_high_byte = data_byte;
          s.phase = PH_CS_LO;
        end
        PH_CS_LO: begin
          s.field_remaining = len16;
          s.phase = (len16 != 16'd0) ? PH_CS_SKIP : PH_CM_LEN;
        end
        PH_CS_SKIP: begin
          s.field_remaining = fr_dec;
          if (fr_dec == 16'd0) s.phase = PH_CM_LEN;
        end
        PH_CM_LEN: begin
          if (data_byte != 8'd0) begin
            s.field_remaining = {8'd0, data_byte};
            s.phase = PH_CM_SKIP;
          end else begin
            s.field_remaining = 16'd2;
            s.phase = PH_EXT_TOTAL;
          end
        end
        PH_CM_SKIP: begin
          s.field_remaining = fr_dec;
          if (fr_dec == 16'd0) begin
            s.field_remaining = 16'd2;
            s.phase = PH_EXT_TOTAL;
          end
        end
        PH_EXT_TOTAL, PH_EXT_SKIP: begin
          s.field_remaining = fr_dec;
          if (fr_dec == 16'd0) begin
            s.phase = PH_EXT_HDR;
            s.field_remaining = EXT_HEADER_BYTES;
          end
        end
        PH_EXT_HDR: begin
          case (s.field_remaining)
            16'd4: begin
              s.extension_kind = {data_byte, 8'd0};
              s.field_remaining = fr_dec;
            end
            16'd3: begin
              s.extension_kind = s.extension_kind | {8'd0, data_byte};
              s.field_remaining = fr_dec;
            end
            16'd2: begin
              s.length_high_byte = data_byte;
              s.field_remaining = fr_dec;
            end
            default: begin
              if (s.extension_kind == SNI_KIND && len16 >= SNI_HEADER_BYTES) begin
                s.phase = PH_SNI_HDR;
                s.field_remaining = SNI_HEADER_BYTES;
              end else if (len16 == 16'd0) begin
                s.phase = PH_EXT_HDR;
                s.field_remaining = EXT_HEADER_BYTES;
              end else begin
                s.phase = PH_EXT_SKIP;
                s.field_remaining = len16;
              end
            end
          endcase
        end
        PH_SNI_HDR: begin
          if (s.field_remaining == 16'd2) s.length_high_byte = data_byte;
          if (s.field_remaining == 16'd1) begin
            s.field_remaining = {s.length_high_byte, data_byte};
            s.phase = ({s.length_high_byte, data_byte} != 16'd0) ? PH_NAME : PH_WAIT_END;
          end else begin
            s.field_remaining = fr_dec;
          end
        end
        PH_NAME: begin
          s.field_remaining = fr_dec;
          last = (fr_dec == 16'd0) || at_end;
          s.name_reported = 1'b1;
          if (last) s.phase = PH_DONE;
          res_valid = 1'b1;
          res = '{name_byte: data_byte, last_of_name: last, status: ST_NAME};
        end
        default: ;
      endcase

      if (!res_valid && at_end && s.phase != PH_DONE) begin
        s.phase = PH_DONE;
        res_valid = 1'b1;
        res = '{name_byte: 8'd0, last_of_name: 1'b1, status: ST_NO_NAME};
      end else if (at_end) begin
        s.phase = PH_DONE;
      end
      if (s.byte_position != POS_MAX) s.byte_position = s.byte_position + 16'd1;
    end
    st_next = s;
  end

endmodule

// ===== hw/rtl/tls_client_hello_sni_extractor.sv =====
// TLS ClientHello server-name extractor, one record byte per request.
// A result is registered and appears on the master side in the cycle after its byte is taken.
// Throughput: one byte per cycle while the master side does not stall; the parse step sits between
// the parser state registers and the output register, which frees each cycle it is taken.
// Reset (rst, synchronous): parser idle, output empty; bytes are ignored
// until one arrives flagged as a record's first byte.
module tls_client_hello_sni_extractor import tlssni_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tuser,   // [0] first_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] name_byte
  output logic       m_tlast,   // last_of_name
  output logic [1:0] m_tuser    // [1:0] status
);

  parse_state_t state;
  parse_state_t state_next;
  logic         res_valid;
  result_t      res;
  logic         accept;

  tlssni_step u_step (
    .st         (state),
    .data_byte  (s_tdata),
    .first_byte (s_tuser),
    .st_next    (state_next),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= STATE_RESET;
      m_tvalid <= 1'b0;
    end else if (accept) begin
      state    <= state_next;
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      m_tdata <= res.name_byte;
      m_tlast <= res.last_of_name;
      m_tuser <= res.status;
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench for tls_client_hello_sni_extractor: TLS records fed byte by byte,
// host name bytes and status results checked against a parse kept in the bench.
// Depends on tlssni_pkg and the extractor RTL.
module tb;
  import tlssni_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tuser;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic [1:0] m_tuser;

  tls_client_hello_sni_extractor dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // parse state mirrored from the block
  phase_t      phase;
  logic [15:0] rec_pos;
  logic [15:0] rec_end;
  logic [15:0] field_left;
  logic [15:0] ext_kind;
  logic [7:0]  len_hi;

  result_t     name_results_q[$];
  logic [7:0]  frame_q[$];
  int          errors = 0;
  int          bytes_sent = 0;
  int          results_predicted = 0;
  int          cycle_count = 0;
  bit          src_gaps = 1;
  bit          sink_gaps = 1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("ERROR t=%0t %s: got %0h, expected %0h", $realtime, field, got, want);
    errors++;
  endtask

  task automatic emit_result(input logic [7:0] b, input logic last, input logic [1:0] st);
    result_t r;
    r.name_byte    = b;
    r.last_of_name = last;
    r.status       = st;
    name_results_q.push_back(r);
    results_predicted++;
  endtask

  // advance the mirrored parse by one accepted request
  task automatic parse_record_byte(input logic [7:0] b, input logic first);
    logic        hit;
    logic        at_end;
    logic [16:0] len;
    hit = 1'b0;
    if (first) begin
      phase      = PH_HEADER;
      rec_pos    = '0;
      rec_end    = '0;
      field_left = '0;
      ext_kind   = '0;
      len_hi     = '0;
    end
    if (phase == PH_IDLE || phase == PH_DONE) return;
    at_end = rec_end != 16'd0 && ({1'b0, rec_pos} + 17'd1) == {1'b0, rec_end};
    case (phase)
      PH_HEADER: begin
        if (rec_pos == 16'd0) begin
          if (b != CONTENT_HANDSHAKE) begin
            phase = PH_DONE;
            hit = 1'b1;
            emit_result(8'h00, 1'b1, ST_NOT_HELLO);
          end
        end else if (rec_pos == 16'd3) begin
          len_hi = b;
        end else if (rec_pos == 16'd4) begin
          len = {1'b0, len_hi, b};
          if (len == 17'd0) begin
            phase = PH_DONE;
            hit = 1'b1;
            emit_result(8'h00, 1'b1, ST_NOT_HELLO);
          end else begin
            len = len + RECORD_HDR_BYTES;
            rec_end = (len > {1'b0, POS_MAX}) ? POS_MAX : len[15:0];
          end
        end else if (rec_pos == 16'd5) begin
          if (b != HS_CLIENT_HELLO) begin
            phase = PH_DONE;
            hit = 1'b1;
            emit_result(8'h00, 1'b1, ST_NOT_HELLO);
          end
        end else if (rec_pos + 16'd1 == SESSION_ID_POS) begin
          phase = PH_SID_LEN;
        end
      end
      PH_SID_LEN: begin
        field_left = {8'h00, b};
        phase = (b != 8'h00) ? PH_SID_SKIP : PH_CS_HI;
      end
      PH_SID_SKIP: begin
        field_left--;
        if (field_left == 16'd0) phase = PH_CS_HI;
      end
      PH_CS_HI: begin
        len_hi = b;
        phase = PH_CS_LO;
      end
      PH_CS_LO: begin
        field_left = {len_hi, b};
        phase = (field_left != 16'd0) ? PH_CS_SKIP : PH_CM_LEN;
      end
      PH_CS_SKIP: begin
        field_left--;
        if (field_left == 16'd0) phase = PH_CM_LEN;
      end
      PH_CM_LEN: begin
        if (b != 8'h00) begin
          field_left = {8'h00, b};
          phase = PH_CM_SKIP;
        end else begin
          field_left = 16'd2;
          phase = PH_EXT_TOTAL;
        end
      end
      PH_CM_SKIP: begin
        field_left--;
        if (field_left == 16'd0) begin
          field_left = 16'd2;
          phase = PH_EXT_TOTAL;
        end
      end
      PH_EXT_TOTAL: begin
        field_left--;
        if (field_left == 16'd0) begin
          field_left = EXT_HEADER_BYTES;
          phase = PH_EXT_HDR;
        end
      end
      PH_EXT_HDR: begin
        if (field_left == 16'd4) begin
          ext_kind = {b, 8'h00};
          field_left--;
        end else if (field_left == 16'd3) begin
          ext_kind = ext_kind | {8'h00, b};
          field_left--;
        end else if (field_left == 16'd2) begin
          len_hi = b;
          field_left--;
        end else if (ext_kind == SNI_KIND && {len_hi, b} >= SNI_HEADER_BYTES) begin
          field_left = SNI_HEADER_BYTES;
          phase = PH_SNI_HDR;
        end else if ({len_hi, b} == 16'd0) begin
          field_left = EXT_HEADER_BYTES;
        end else begin
          field_left = {len_hi, b};
          phase = PH_EXT_SKIP;
        end
      end
      PH_EXT_SKIP: begin
        field_left--;
        if (field_left == 16'd0) begin
          field_left = EXT_HEADER_BYTES;
          phase = PH_EXT_HDR;
        end
      end
      PH_SNI_HDR: begin
        if (field_left == 16'd2) len_hi = b;
        if (field_left == 16'd1) begin
          field_left = {len_hi, b};
          phase = (field_left != 16'd0) ? PH_NAME : PH_WAIT_END;
        end else begin
          field_left--;
        end
      end
      PH_NAME: begin
        field_left--;
        hit = 1'b1;
        emit_result(b, field_left == 16'd0 || at_end, ST_NAME);
        if (field_left == 16'd0 || at_end) phase = PH_DONE;
      end
      default: ;
    endcase
    if (!hit && at_end && phase != PH_DONE) begin
      phase = PH_DONE;
      emit_result(8'h00, 1'b1, ST_NO_NAME);
    end else if (at_end) begin
      phase = PH_DONE;
    end
    if (rec_pos != POS_MAX) rec_pos++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic first);
    int gap;
    gap = src_gaps ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    parse_record_byte(b, first);
    bytes_sent++;
  endtask

  // first count bytes of the frame (first one flagged), then stray trailing bytes
  task automatic send_frame(input int count, input int trailing);
    for (int i = 0; i < count && i < frame_q.size(); i++)
      send_byte(frame_q[i], i == 0);
    repeat (trailing) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  function automatic void push_word(input logic [15:0] w);
    frame_q.push_back(w[15:8]);
    frame_q.push_back(w[7:0]);
  endfunction

  task automatic build_hello(input int sid_len, input int cs_len, input int cm_len,
                             input int n_ext, input bit with_sni, input bit short_sni,
                             input int name_len, input int len_delta);
    int          ext_start;
    int          ext_len;
    int          body;
    logic [15:0] w;
    frame_q = {};
    frame_q.push_back(CONTENT_HANDSHAKE);
    push_word(16'h0301);
    push_word(16'h0000);
    frame_q.push_back(HS_CLIENT_HELLO);
    repeat (3) frame_q.push_back(8'($urandom_range(0, 255)));
    push_word(16'h0303);
    repeat (32) frame_q.push_back(8'($urandom_range(0, 255)));
    w = 16'(sid_len);
    frame_q.push_back(w[7:0]);
    repeat (sid_len) frame_q.push_back(8'($urandom_range(0, 255)));
    w = 16'(cs_len);
    push_word(w);
    repeat (cs_len) frame_q.push_back(8'($urandom_range(0, 255)));
    w = 16'(cm_len);
    frame_q.push_back(w[7:0]);
    repeat (cm_len) frame_q.push_back(8'($urandom_range(0, 255)));
    ext_start = frame_q.size();
    push_word(16'h0000);
    repeat (n_ext) begin
      ext_len = $urandom_range(0, 6);
      frame_q.push_back(8'($urandom_range(0, 255)));
      frame_q.push_back(8'($urandom_range(1, 255)));
      w = 16'(ext_len);
      push_word(w);
      repeat (ext_len) frame_q.push_back(8'($urandom_range(0, 255)));
    end
    if (with_sni) begin
      push_word(SNI_KIND);
      if (short_sni) begin
        ext_len = $urandom_range(0, 4);
        w = 16'(ext_len);
        push_word(w);
        repeat (ext_len) frame_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        w = 16'(name_len + 5);
        push_word(w);
        w = 16'(name_len + 3);
        push_word(w);
        frame_q.push_back(8'h00);
        w = 16'(name_len);
        push_word(w);
        repeat (name_len) frame_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    w = 16'(frame_q.size() - ext_start - 2);
    frame_q[ext_start]     = w[15:8];
    frame_q[ext_start + 1] = w[7:0];
    body = frame_q.size() - 5 + len_delta;
    if (body < 1) body = 1;
    w = 16'(body);
    frame_q[3] = w[15:8];
    frame_q[4] = w[7:0];
  endtask

  task automatic test_ignored_before_start();
    send_byte(CONTENT_HANDSHAKE, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_client_hello_names();
    build_hello(0, 2, 1, 0, 1'b1, 1'b0, 5, 0);
    send_frame(frame_q.size(), 0);
    sink_gaps = 1'b0;
    build_hello(32, 4, 0, 2, 1'b1, 1'b0, 12, 0);
    send_frame(frame_q.size(), 2);
    src_gaps = 1'b0;
    build_hello(3, 0, 2, 1, 1'b1, 1'b0, 1, 0);
    send_frame(frame_q.size(), 0);
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
  endtask

  task automatic test_rejected_records();
    build_hello(1, 2, 1, 0, 1'b1, 1'b0, 4, 0);
    frame_q[0] = 8'h17;
    send_frame(frame_q.size(), 0);
    build_hello(1, 2, 1, 0, 1'b1, 1'b0, 4, 0);
    frame_q[5] = 8'h02;
    send_frame(frame_q.size(), 0);
    build_hello(1, 2, 1, 0, 1'b1, 1'b0, 4, 0);
    frame_q[3] = 8'h00;
    frame_q[4] = 8'h00;
    send_frame(12, 0);
  endtask

  task automatic test_record_limits();
    // no server name at all
    build_hello(2, 2, 1, 2, 1'b0, 1'b0, 0, 0);
    send_frame(frame_q.size(), 0);
    // empty host name
    build_hello(0, 2, 1, 1, 1'b1, 1'b0, 0, 0);
    send_frame(frame_q.size(), 1);
    // server_name extension too short to hold a name
    build_hello(0, 2, 1, 0, 1'b1, 1'b1, 0, 0);
    send_frame(frame_q.size(), 0);
    // name cut short by the record length
    build_hello(0, 4, 1, 1, 1'b1, 1'b0, 8, -3);
    send_frame(frame_q.size(), 3);
    // record length far past the bytes sent, record end saturates
    build_hello(0, 2, 1, 0, 1'b1, 1'b0, 6, 0);
    frame_q[3] = 8'hFF;
    frame_q[4] = 8'hFF;
    send_frame(frame_q.size(), 2);
    // restart in the middle of a record
    build_hello(4, 2, 1, 1, 1'b1, 1'b0, 6, 0);
    send_frame(30, 0);
    build_hello(4, 2, 1, 1, 1'b1, 1'b0, 6, 0);
    send_frame(frame_q.size() - 2, 0);
  endtask

  task automatic test_random_records();
    int kind;
    int records;
    int delta;
    int count;
    records = 0;
    while ((bytes_sent < 600 || results_predicted < 48) && records < 300) begin
      records++;
      src_gaps  = $urandom_range(0, 3) != 0;
      sink_gaps = $urandom_range(0, 3) != 0;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        frame_q = {};
        repeat ($urandom_range(1, 20)) frame_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) frame_q[0] = CONTENT_HANDSHAKE;
        send_frame(frame_q.size(), 0);
      end else begin
        case ($urandom_range(0, 5))
          0: delta = -$urandom_range(1, 6);
          1: delta = $urandom_range(1, 4);
          default: delta = 0;
        endcase
        build_hello(($urandom_range(0, 3) == 0) ? 32 : $urandom_range(0, 4),
                    2 * $urandom_range(0, 4), $urandom_range(0, 2), $urandom_range(0, 3),
                    $urandom_range(0, 4) != 0, $urandom_range(0, 9) == 0,
                    ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12), delta);
        count = frame_q.size();
        if (kind == 1)
          frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom_range(0, 255));
        if (kind == 2) count = $urandom_range(1, frame_q.size() - 1);
        send_frame(count, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
      end
    end
  endtask

  // result side: random stall (when sink_gaps is set) before each request is taken
  initial begin
    int stall;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = sink_gaps ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (name_results_q.size() == 0) begin
        report_mismatch("unexpected request", m_tdata, 8'h00);
      end else begin
        want = name_results_q.pop_front();
        if (m_tdata !== want.name_byte)
          report_mismatch("name_byte", m_tdata, want.name_byte);
        if (m_tlast !== want.last_of_name)
          report_mismatch("last_of_name", {7'd0, m_tlast}, {7'd0, want.last_of_name});
        if (m_tuser !== want.status)
          report_mismatch("status", {6'd0, m_tuser}, {6'd0, want.status});
      end
    end
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= 8'h00;
    s_tuser  <= 1'b0;
    phase      = PH_IDLE;
    rec_pos    = '0;
    rec_end    = '0;
    field_left = '0;
    ext_kind   = '0;
    len_hi     = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_ignored_before_start();
    test_client_hello_names();
    test_rejected_records();
    test_record_limits();
    test_random_records();
    s_tvalid <= 1'b0;
    while (name_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
